@@ rtl/core/gclmp_pkg.sv @@
// ----------------------------------------------------------------------------
// gclmp_pkg
// Shared types and constants of the linear move planner core.
// ----------------------------------------------------------------------------
package gclmp_pkg;

  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned MIN_DISTANCE_DEF = 7;

  // feed is given per minute, rates per second
  localparam int unsigned FeedDiv = 60;

  localparam int unsigned MUL_A_W = 64;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned RAD_W   = 66;
  localparam int unsigned ROOT_W  = 36;

  localparam int unsigned NUM_W   = 96;
  localparam int unsigned DEN_W   = 42;

  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 192;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned ADDR_W     = 4;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_MOVE = 3'd1;
  localparam logic [2:0] OP_ABS  = 3'd2;
  localparam logic [2:0] OP_REL  = 3'd3;
  localparam logic [2:0] OP_HOME = 3'd4;

  localparam logic [1:0] REG_SPM_X = 2'd0;
  localparam logic [1:0] REG_SPM_Y = 2'd1;
  localparam logic [1:0] REG_SPM_Z = 2'd2;

  localparam logic [31:0] SPM_RESET = 32'h0001_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } gclmp_stat_t;

endpackage

@@ rtl/core/gclmp_mul.sv @@
// ----------------------------------------------------------------------------
// gclmp_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gclmp_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [gclmp_pkg::MUL_A_W-1:0]       a_i,
  input  logic [gclmp_pkg::MUL_B_W-1:0]       b_i,
  output gclmp_pkg::gclmp_stat_t              stat_o,
  output logic [gclmp_pkg::MUL_P_W-1:0]       p_o
);
  import gclmp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_B_W);

  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic [MUL_A_W-1:0] a_q, hi_q;
  logic [MUL_B_W-1:0] lo_q;
  logic [MUL_A_W:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[MUL_A_W:1];
      lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
    end
  end

  assign p_o         = {hi_q, lo_q};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/core/gclmp_sqrt.sv @@
// ----------------------------------------------------------------------------
// gclmp_sqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module gclmp_sqrt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [gclmp_pkg::RAD_W-1:0]         rad_i,
  output gclmp_pkg::gclmp_stat_t              stat_o,
  output logic [gclmp_pkg::ROOT_W-1:0]        root_o
);
  import gclmp_pkg::*;

  localparam int unsigned RW    = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [RW-1:0]     rad_q;
  logic [REM_W-1:0]  rem_q, rem_sh, trial;
  logic [ROOT_W-1:0] root_q;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RW-1:RW-2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rad_q  <= RW'(rad_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/core/gclmp_div.sv @@
// ----------------------------------------------------------------------------
// gclmp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gclmp_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [gclmp_pkg::NUM_W-1:0]         num_i,
  input  logic [gclmp_pkg::DEN_W-1:0]         den_i,
  output gclmp_pkg::gclmp_stat_t              stat_o,
  output logic [gclmp_pkg::NUM_W-1:0]         quo_o
);
  import gclmp_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [DEN_W:0]   rem_sh;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
        num_q <= {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo_o       = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/core/gcode_linear_move_planner_core.sv @@
// ----------------------------------------------------------------------------
// gcode_linear_move_planner_core
// Linear move planner: position, feed and mode tracking, axis step rates.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result transfer. Mode, home
// and no-op commands go straight to the result. A linear move runs three
// serial squares, a square root, and then per axis a steps-times-feed
// product, a delta product and a divide; a short move or a move with feed at
// most zero ends after the square root. The bit-serial units work one bit
// per cycle through the multiplier, root and divider.
module gcode_linear_move_planner_core #(
  parameter int unsigned FRAC_BITS    = gclmp_pkg::FRAC_BITS_DEF,
  parameter int unsigned MIN_DISTANCE = gclmp_pkg::MIN_DISTANCE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: has_feed, feed_value, has_x, x_value, has_y, y_value, has_z,
  //        z_value, zero pad
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [gclmp_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: operation
  input  logic [gclmp_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata: pos_x, pos_y, pos_z, rate_x, rate_y, rate_z
  output logic [gclmp_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // tuser: move_planned
  output logic [gclmp_pkg::OUT_USER_W-1:0]    m_axis_tuser_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gclmp_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import gclmp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DELTA = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_SPF   = 3'd4;
  localparam logic [2:0] ST_DMUL  = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam int unsigned SAT_LSB = 32 + FRAC_BITS;

  function automatic logic [31:0] sat_add(logic [31:0] p, logic [31:0] v);
    logic [32:0] s;
    s = {p[31], p} + {v[31], v};
    if (s[32] != s[31]) sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else                sat_add = s[31:0];
  endfunction

  function automatic logic [32:0] abs_diff(logic [31:0] t, logic [31:0] p);
    logic [32:0] d;
    d = {t[31], t} - {p[31], p};
    abs_diff = d[32] ? (33'd0 - d) : d;
  endfunction

  logic [2:0]  state_q, state_d;
  logic [1:0]  axis_q, axis_d;
  logic        go_q, go_d;
  logic        planned_q, planned_d;
  logic        abs_q, abs_d;
  logic [31:0] feed_q, feed_d;
  logic [31:0] pos_q [3];
  logic [31:0] pos_d [3];
  logic [31:0] tgt_q [3];
  logic [31:0] tgt_d [3];
  logic [31:0] rate_q [3];
  logic [31:0] rate_d [3];
  logic [32:0] mag_q [3];
  logic [32:0] mag_d [3];
  logic [31:0] spm_q [3];
  logic [RAD_W-1:0]  sumsq_q, sumsq_d;
  logic [ROOT_W-1:0] dist_q, dist_d;
  logic [62:0] v_q, v_d;

  logic        m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic        m_user_q;
  logic        out_load;

  logic        in_fire;
  logic [2:0]  op;
  logic        has_feed;
  logic [31:0] feed_in;
  logic        has_ax [3];
  logic [31:0] val_ax [3];

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  gclmp_stat_t        mul_st, sqrt_st, div_st;
  logic [ROOT_W-1:0]  root;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   quo;
  logic [31:0]        rate_sat;

  assign op       = s_axis_tuser_i;
  assign has_feed = s_axis_tdata_i[0];
  assign feed_in  = s_axis_tdata_i[32:1];
  assign has_ax[0] = s_axis_tdata_i[33];
  assign val_ax[0] = s_axis_tdata_i[65:34];
  assign has_ax[1] = s_axis_tdata_i[66];
  assign val_ax[1] = s_axis_tdata_i[98:67];
  assign has_ax[2] = s_axis_tdata_i[99];
  assign val_ax[2] = s_axis_tdata_i[131:100];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      REG_SPM_X: prdata = spm_q[0];
      REG_SPM_Y: prdata = spm_q[1];
      REG_SPM_Z: prdata = spm_q[2];
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_q[0] <= SPM_RESET;
      spm_q[1] <= SPM_RESET;
      spm_q[2] <= SPM_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_SPM_X: spm_q[0] <= pwdata;
        REG_SPM_Y: spm_q[1] <= pwdata;
        REG_SPM_Z: spm_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // serial units; the multiplier is shared by the product steps
  always_comb begin
    unique case (state_q)
      ST_SPF: begin
        mul_a = MUL_A_W'(spm_q[axis_q]);
        mul_b = {2'b00, feed_q[30:0]};
      end
      ST_DMUL: begin
        mul_a = {1'b0, v_q};
        mul_b = mag_q[axis_q];
      end
      default: begin
        mul_a = MUL_A_W'(mag_q[axis_q]);
        mul_b = mag_q[axis_q];
      end
    endcase
  end

  gclmp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && (state_q == ST_SQ || state_q == ST_SPF || state_q == ST_DMUL)),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_st),
    .p_o     (mul_p)
  );

  gclmp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && (state_q == ST_SQRT)),
    .rad_i   (sumsq_q),
    .stat_o  (sqrt_st),
    .root_o  (root)
  );

  assign den = DEN_W'(dist_q) * DEN_W'(FeedDiv);

  gclmp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && (state_q == ST_DIV)),
    .num_i   (mul_p[NUM_W-1:0]),
    .den_i   (den),
    .stat_o  (div_st),
    .quo_o   (quo)
  );

  assign rate_sat = (quo[NUM_W-1:SAT_LSB] != '0) ? 32'hFFFF_FFFF
                                                 : quo[SAT_LSB-1:FRAC_BITS];

  // sequencer
  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    go_d      = 1'b0;
    planned_d = planned_q;
    abs_d     = abs_q;
    feed_d    = feed_q;
    pos_d     = pos_q;
    tgt_d     = tgt_q;
    rate_d    = rate_q;
    mag_d     = mag_q;
    sumsq_d   = sumsq_q;
    dist_d    = dist_q;
    v_d       = v_q;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          planned_d = 1'b0;
          if (has_feed) feed_d = feed_in;
          state_d = ST_DONE;
          unique case (op)
            OP_MOVE: begin
              for (int k = 0; k < 3; k++) begin
                if (!has_ax[k])  tgt_d[k] = pos_q[k];
                else if (abs_q)  tgt_d[k] = val_ax[k];
                else             tgt_d[k] = sat_add(pos_q[k], val_ax[k]);
              end
              state_d = ST_DELTA;
            end
            OP_ABS:  abs_d = 1'b1;
            OP_REL:  abs_d = 1'b0;
            OP_HOME: begin
              for (int k = 0; k < 3; k++) pos_d[k] = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DELTA: begin
        for (int k = 0; k < 3; k++) mag_d[k] = abs_diff(tgt_q[k], pos_q[k]);
        sumsq_d = '0;
        axis_d  = 2'd0;
        go_d    = 1'b1;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        if (mul_st.done) begin
          sumsq_d = sumsq_q + mul_p[RAD_W-1:0];
          go_d    = 1'b1;
          if (axis_q == 2'd2) state_d = ST_SQRT;
          else                axis_d  = axis_q + 2'd1;
        end
      end
      ST_SQRT: begin
        if (sqrt_st.done) begin
          dist_d = root;
          if (root < ROOT_W'(MIN_DISTANCE)) begin
            state_d = ST_DONE;
          end else if ($signed(feed_q) <= 0) begin
            for (int k = 0; k < 3; k++) begin
              rate_d[k] = '0;
              pos_d[k]  = tgt_q[k];
            end
            planned_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            axis_d  = 2'd0;
            go_d    = 1'b1;
            state_d = ST_SPF;
          end
        end
      end
      ST_SPF: begin
        if (mul_st.done) begin
          v_d     = mul_p[62:0];
          go_d    = 1'b1;
          state_d = ST_DMUL;
        end
      end
      ST_DMUL: begin
        if (mul_st.done) begin
          go_d    = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          rate_d[axis_q] = rate_sat;
          if (axis_q == 2'd2) begin
            for (int k = 0; k < 3; k++) pos_d[k] = tgt_q[k];
            planned_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            axis_d  = axis_q + 2'd1;
            go_d    = 1'b1;
            state_d = ST_SPF;
          end
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      axis_q    <= '0;
      go_q      <= 1'b0;
      planned_q <= 1'b0;
      abs_q     <= 1'b1;
      feed_q    <= '0;
      m_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        pos_q[k]  <= '0;
        rate_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      axis_q    <= axis_d;
      go_q      <= go_d;
      planned_q <= planned_d;
      abs_q     <= abs_d;
      feed_q    <= feed_d;
      pos_q     <= pos_d;
      rate_q    <= rate_d;
      if (out_load)             m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q   <= tgt_d;
    mag_q   <= mag_d;
    sumsq_q <= sumsq_d;
    dist_q  <= dist_d;
    v_q     <= v_d;
    if (out_load) begin
      m_user_q <= planned_q;
      m_data_q <= {rate_q[2], rate_q[1], rate_q[0], pos_q[2], pos_q[1], pos_q[0]};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // each serial unit finishes only in a step that uses it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> (state_q == ST_SQ || state_q == ST_SPF || state_q == ST_DMUL))
    else $error("multiplier finished outside a product step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_st.done |-> (state_q == ST_SQRT))
    else $error("square root finished outside its step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_DIV))
    else $error("divider finished outside its step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("new command taken while one is in flight");

endmodule
